// ----- src/pisc_pkg.sv -----
// Shared types, widths and register indexes for the PI speed controller.
`default_nettype none

package pisc_pkg;

	localparam int SIG_W      = 16;
	localparam int GAIN_W     = 24;
	localparam int ERR_W      = SIG_W + 1;
	localparam int PROD_W     = ERR_W + GAIN_W + 1;
	localparam int TERM_W     = PROD_W - 16;
	localparam int SUM_W      = TERM_W + 1;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PROPORTIONAL_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN     = 2'd1;

	localparam logic ACTION_RUN   = 1'b0;
	localparam logic ACTION_CLEAR = 1'b1;

	typedef struct packed {
		logic                    action;
		logic signed [SIG_W-1:0] reference;
		logic signed [SIG_W-1:0] feedback;
	} in_item_t;

	typedef struct packed {
		logic signed [SIG_W-1:0] drive;
		logic                    integral_cut;
		logic                    saturated;
	} out_item_t;

endpackage

`default_nettype wire

// ----- src/pisc_step.sv -----
// Combinational step: error, integral update with clamp and cut, drive clamp, clear.
`default_nettype none

module pisc_step (
	input  wire pisc_pkg::in_item_t                 item,
	input  wire logic signed [pisc_pkg::SIG_W-1:0]  integral,
	input  wire logic [pisc_pkg::GAIN_W-1:0]        proportional_gain,
	input  wire logic [pisc_pkg::GAIN_W-1:0]        integral_gain,
	output pisc_pkg::out_item_t                     result,
	output logic signed [pisc_pkg::SIG_W-1:0]       integral_next
);

	localparam logic signed [pisc_pkg::SUM_W-1:0] SUM_MAX = pisc_pkg::SUM_W'(32767);
	localparam logic signed [pisc_pkg::SUM_W-1:0] SUM_MIN = -pisc_pkg::SUM_W'(32768);

	logic signed [pisc_pkg::ERR_W-1:0]  err;
	logic signed [pisc_pkg::PROD_W-1:0] kp_prod;
	logic signed [pisc_pkg::PROD_W-1:0] ki_prod;
	logic signed [pisc_pkg::SUM_W-1:0]  acc;
	logic signed [pisc_pkg::SUM_W-1:0]  drv;
	logic signed [pisc_pkg::SIG_W-1:0]  acc_clamped;
	logic signed [pisc_pkg::SIG_W-1:0]  integral_run;
	logic [pisc_pkg::ERR_W-1:0]         err_abs;
	logic [pisc_pkg::SIG_W:0]           ref_abs;
	logic [20:0]                        err_x10;
	logic [20:0]                        ref_x7;
	logic                               cut;
	logic                               hit;
	logic signed [pisc_pkg::SIG_W-1:0]  drv_clamped;

	assign err = pisc_pkg::ERR_W'(item.reference) - pisc_pkg::ERR_W'(item.feedback);

	// Gains are unsigned, so a zero sign bit keeps the product signed and exact.
	assign kp_prod = err * $signed({1'b0, proportional_gain});
	assign ki_prod = err * $signed({1'b0, integral_gain});

	// Dropping the low 16 bits of a two's complement value rounds toward minus infinity.
	assign acc = pisc_pkg::SUM_W'(integral)
		+ pisc_pkg::SUM_W'($signed(ki_prod[pisc_pkg::PROD_W-1:16]));

	always_comb begin
		if (acc > SUM_MAX) begin
			acc_clamped = 16'sh7FFF;
		end else if (acc < SUM_MIN) begin
			acc_clamped = -16'sh8000;
		end else begin
			acc_clamped = acc[pisc_pkg::SIG_W-1:0];
		end
	end

	// Large-error test 10*|err| > 7*|ref|, exact and symmetric in the sign of ref.
	assign err_abs = err[pisc_pkg::ERR_W-1] ? pisc_pkg::ERR_W'(-err) : pisc_pkg::ERR_W'(err);
	assign ref_abs = item.reference[pisc_pkg::SIG_W-1]
		? (pisc_pkg::SIG_W+1)'(-(pisc_pkg::SIG_W+1)'(item.reference))
		: (pisc_pkg::SIG_W+1)'(item.reference);
	assign err_x10 = (21'(err_abs) << 3) + (21'(err_abs) << 1);
	assign ref_x7  = (21'(ref_abs) << 3) - 21'(ref_abs);
	assign cut     = err_x10 > ref_x7;

	assign integral_run = cut ? '0 : acc_clamped;

	assign drv = pisc_pkg::SUM_W'($signed(kp_prod[pisc_pkg::PROD_W-1:16]))
		+ pisc_pkg::SUM_W'(integral_run);

	always_comb begin
		hit = 1'b1;
		if (drv > SUM_MAX) begin
			drv_clamped = 16'sh7FFF;
		end else if (drv < SUM_MIN) begin
			drv_clamped = -16'sh8000;
		end else begin
			drv_clamped = drv[pisc_pkg::SIG_W-1:0];
			hit         = 1'b0;
		end
	end

	always_comb begin
		if (item.action == pisc_pkg::ACTION_CLEAR) begin
			integral_next       = '0;
			result.drive        = '0;
			result.integral_cut = 1'b0;
			result.saturated    = 1'b0;
		end else begin
			integral_next       = integral_run;
			result.drive        = drv_clamped;
			result.integral_cut = cut;
			result.saturated    = hit;
		end
	end

endmodule

`default_nettype wire

// ----- src/pi_speed_controller_windup_cut.sv -----
// PI speed controller with integral clamp and large-error integral cut, top level.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one control step per beat:
//   action (run or clear), reference and feedback, both signed Q1.15.
//   Output channel out_valid/out_stall/out_item returns one beat per input
//   beat, in order: drive (Q1.15), integral_cut and saturated flags.
//   Gains are written on the cfg channel (index 0 = proportional, 1 = integral,
//   unsigned Q8.16); cfg_ready is always high. Write gains only while idle.
// Timing:
//   An accepted beat lands in the input register, the step logic runs in the
//   following cycle and the result is loaded into the output register at the
//   end of that cycle unless out_stall holds a full output register.
//   Throughput is one beat per cycle while the output is not stalled; the
//   integral register closes its loop through the combinational step logic.
// Reset:
//   arst_n clears both gains, the integral and all valid flags.
// Backpressure:
//   While out_stall holds a full output register, the input register holds its
//   beat and in_stall rises once it is full too; nothing is lost or repeated.
`default_nettype none

module pi_speed_controller_windup_cut (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire pisc_pkg::in_item_t                 in_item,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output pisc_pkg::out_item_t                     out_item,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pisc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pisc_pkg::GAIN_W-1:0]        cfg_data
);

	logic [pisc_pkg::GAIN_W-1:0]       kp_q;
	logic [pisc_pkg::GAIN_W-1:0]       ki_q;
	logic signed [pisc_pkg::SIG_W-1:0] integral_q;
	logic signed [pisc_pkg::SIG_W-1:0] integral_next;
	pisc_pkg::in_item_t                item_s1;
	logic                              valid_s1;
	pisc_pkg::out_item_t               result;
	pisc_pkg::out_item_t               out_q;
	logic                              out_valid_q;
	logic                              out_free;
	logic                              advance;
	logic                              in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pisc_pkg::CFG_PROPORTIONAL_GAIN: kp_q <= cfg_data;
				pisc_pkg::CFG_INTEGRAL_GAIN:     ki_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	pisc_step u_step (
		.item              (item_s1),
		.integral          (integral_q),
		.proportional_gain (kp_q),
		.integral_gain     (ki_q),
		.result            (result),
		.integral_next     (integral_next)
	);

	// The integral moves only when its step is handed to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (advance) begin
			integral_q <= integral_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire
